// ===== rtl/bfs_pkg.sv =====
// Shared constants and saturation helpers for the boid steering block.
`timescale 1ns / 1ps
`default_nettype none

package bfs_pkg;

    localparam int DATA_W    = 32;
    localparam int ACC_W     = 40;
    localparam int SPEED_W   = 31;
    localparam int TOTAL_W   = 7;
    localparam int MUL_W     = 64;

    // Clamp a 33-bit signed value to the 32-bit signed range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1])
        begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Clamp a 41-bit signed value to the 40-bit signed range.
    function automatic logic signed [ACC_W-1:0] sat40(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[ACC_W] != v[ACC_W-1])
        begin
            r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

    // Magnitude of a 32-bit signed value; the most negative value maps to 2^31.
    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    function automatic logic [ACC_W-1:0] mag40(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/boid_flocking_steering.sv =====
// Boid steering unit: alignment, cohesion and separation from a neighbour stream.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Signals                                   Direction  Transfer
//  in        in_valid/in_ready, self_*, nbr_*, flags   into       valid and ready high
//  out       out_valid/out_ready, align/cohere/sep     out of     valid and ready high
//  cfg       cfg_we, cfg_wdata (max_speed)             into       cfg_we high, no wait
//
//  Divisions and roots use one shared 65-bit subtractor (restoring division
//  and square root, one quotient bit or root bit a cycle), products use one
//  registered 32x32 multiplier, all under the sequencer below.
//  A skipped item only passes the capture, accumulate and next states. A
//  neighbour costs two products, a sum and an epsilon test, and beyond epsilon
//  two divisions of 32+2*FRAC_BITS steps with a set-up and a finish state each.
//  A closing item adds per steering vector two 40-step averages, a 32-step root
//  and two 62-step divisions, and then hands the result over.
//  The asynchronous reset clears the sums, counters, sequencer and output valid;
//  no clearing pass is needed. in_ready is high only while the sequencer idles,
//  and a finished result waits in the output register while the next item is
//  taken; a closing item stalls only if the previous result is still unread.

module boid_flocking_steering
    import bfs_pkg::*;
#(
    parameter int MAX_NEIGHBORS = 64,
    parameter int FRAC_BITS     = 16
)
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_we,
    input  wire        [SPEED_W-1:0]   cfg_wdata,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire signed [DATA_W-1:0]    self_pos_x,
    input  wire signed [DATA_W-1:0]    self_pos_y,
    input  wire signed [DATA_W-1:0]    self_vel_x,
    input  wire signed [DATA_W-1:0]    self_vel_y,
    input  wire signed [DATA_W-1:0]    nbr_pos_x,
    input  wire signed [DATA_W-1:0]    nbr_pos_y,
    input  wire signed [DATA_W-1:0]    nbr_vel_x,
    input  wire signed [DATA_W-1:0]    nbr_vel_y,
    input  wire                        is_self,
    input  wire                        last,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic signed [DATA_W-1:0]   align_x,
    output logic signed [DATA_W-1:0]   align_y,
    output logic signed [DATA_W-1:0]   cohere_x,
    output logic signed [DATA_W-1:0]   cohere_y,
    output logic signed [DATA_W-1:0]   separate_x,
    output logic signed [DATA_W-1:0]   separate_y,
    output logic       [TOTAL_W-1:0]   neighbor_total
);

    // Epsilon is 0.0001 rounded to the fixed-point grid; tests use its square.
    localparam longint EPS_RAW = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [MUL_W-1:0] EPS_SQ = MUL_W'(EPS_RAW * EPS_RAW);
    localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
    localparam int SEP_N  = DATA_W + 2 * FRAC_BITS;
    localparam int AVG_N  = ACC_W;
    localparam int W_N    = 2 * DATA_W - 2;
    localparam int NW     = (SEP_N > MUL_W) ? SEP_N : MUL_W;
    localparam int STEP_W = $clog2(NW + 1);
    localparam int REM_W  = MUL_W + 1;
    localparam logic [DATA_W-1:0] CAP_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] CAP_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_ACC, S_MUL_X, S_MUL_Y, S_SUM, S_TEST, S_DLOAD, S_DIV,
        S_DDONE, S_SQRT, S_SQDONE, S_MULW, S_NEXT, S_JOB, S_JOB_NEXT, S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_SEP, OP_AVG, OP_W
    } op_t;

    state_t                      state_reg;
    op_t                         op_reg;
    logic                        ax_reg;
    logic                        fin_reg;
    logic        [1:0]           job_reg;
    logic        [SPEED_W-1:0]   max_speed_reg;

    // Captured item.
    logic signed [DATA_W-1:0]    spx_reg, spy_reg, svx_reg, svy_reg;
    logic signed [DATA_W-1:0]    npx_reg, npy_reg, nvx_reg, nvy_reg;
    logic                        skip_reg, last_reg;

    // Running sums and counts.
    logic signed [ACC_W-1:0]     vsx_reg, vsy_reg, psx_reg, psy_reg, asx_reg, asy_reg;
    logic        [CNT_W-1:0]     mate_reg, away_reg;

    // Working vector, multiplier and shared divide / root unit.
    logic signed [DATA_W-1:0]    vx_reg, vy_reg;
    logic        [MUL_W-1:0]     prod_reg;
    logic        [MUL_W-1:0]     sq_reg;
    logic        [NW-1:0]        num_reg;
    logic        [MUL_W-1:0]     rem_reg;
    logic        [MUL_W-1:0]     den_reg;
    logic        [DATA_W-1:0]    q_reg;
    logic                        ovf_reg;
    logic        [DATA_W-1:0]    cap_reg;
    logic                        neg_reg;
    logic        [STEP_W-1:0]    step_reg;
    logic        [DATA_W-1:0]    len_reg;

    logic signed [DATA_W-1:0]    res_reg [6];
    logic signed [DATA_W-1:0]    out_res_reg [6];
    logic        [TOTAL_W-1:0]   out_total_reg;
    logic                        out_valid_reg;

    logic        [DATA_W-1:0]    mag_x, mag_y, mag_ax;
    logic signed [DATA_W-1:0]    v_ax;
    logic        [DATA_W-1:0]    mul_a, mul_b;
    logic signed [ACC_W-1:0]     sel_sum;
    logic        [CNT_W-1:0]     job_cnt;
    logic        [REM_W-1:0]     sub_a, sub_b;
    logic        [REM_W:0]       diff;
    logic                        ge;
    logic        [DATA_W-1:0]    q_sat;
    logic signed [DATA_W-1:0]    div_res;
    logic signed [DATA_W-1:0]    avg_res;
    logic        [2:0]           ridx;
    logic        [NW-1:0]        ld_num;
    logic        [STEP_W-1:0]    ld_n;
    logic        [MUL_W-1:0]     ld_den;
    logic        [DATA_W-1:0]    ld_cap;
    logic                        ld_neg;
    logic                        emit_go;

    assign mag_x  = mag32(vx_reg);
    assign mag_y  = mag32(vy_reg);
    assign v_ax   = ax_reg ? vy_reg : vx_reg;
    assign mag_ax = mag32(v_ax);
    assign ridx   = {job_reg, ax_reg};

    always_comb
    begin
        case (state_reg)
            S_MUL_X:
            begin
                mul_a = mag_x;
                mul_b = mag_x;
            end
            S_MUL_Y:
            begin
                mul_a = mag_y;
                mul_b = mag_y;
            end
            default:
            begin
                mul_a = mag_ax;
                mul_b = {1'b0, max_speed_reg};
            end
        endcase
    end

    always_comb
    begin
        case ({job_reg, ax_reg})
            3'b000:  sel_sum = vsx_reg;
            3'b001:  sel_sum = vsy_reg;
            3'b010:  sel_sum = psx_reg;
            3'b011:  sel_sum = psy_reg;
            3'b100:  sel_sum = asx_reg;
            default: sel_sum = asy_reg;
        endcase
        job_cnt = (job_reg == 2'd2) ? away_reg : mate_reg;
    end

    // Operands for the next division, left-aligned in the numerator shifter.
    always_comb
    begin
        case (op_reg)
            OP_SEP:
            begin
                ld_num = NW'(mag_ax) << (NW - DATA_W);
                ld_n   = STEP_W'(SEP_N);
                ld_den = sq_reg;
                ld_cap = CAP_POS;
                ld_neg = v_ax[DATA_W-1];
            end
            OP_AVG:
            begin
                ld_num = NW'(mag40(sel_sum)) << (NW - AVG_N);
                ld_n   = STEP_W'(AVG_N);
                ld_den = MUL_W'(job_cnt);
                ld_cap = sel_sum[ACC_W-1] ? CAP_NEG : CAP_POS;
                ld_neg = sel_sum[ACC_W-1];
            end
            default:
            begin
                ld_num = NW'(prod_reg[W_N-1:0]) << (NW - W_N);
                ld_n   = STEP_W'(W_N);
                ld_den = MUL_W'(len_reg);
                ld_cap = CAP_POS;
                ld_neg = v_ax[DATA_W-1];
            end
        endcase
    end

    // The shared subtractor: one restoring division bit or one root bit.
    always_comb
    begin
        if (state_reg == S_SQRT)
        begin
            sub_a = {rem_reg[MUL_W-2:0], num_reg[NW-1], num_reg[NW-2]};
            sub_b = REM_W'({q_reg, 2'b01});
        end
        else
        begin
            sub_a = {rem_reg, num_reg[NW-1]};
            sub_b = {1'b0, den_reg};
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = ~diff[REM_W];
    end

    assign q_sat   = (ovf_reg || (q_reg > cap_reg)) ? cap_reg : q_reg;
    assign div_res = neg_reg ? -q_sat : q_sat;
    // Cohesion steers towards the mean position relative to the boid itself.
    assign avg_res = (job_reg == 2'd1) ? sat32(33'(div_res) - 33'(spx_reg)) : div_res;

    assign emit_go = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_W'(mul_a) * MUL_W'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_SEP;
            ax_reg        <= 1'b0;
            fin_reg       <= 1'b0;
            job_reg       <= 2'd0;
            max_speed_reg <= SPEED_W'(262144);
            vsx_reg       <= '0;
            vsy_reg       <= '0;
            psx_reg       <= '0;
            psy_reg       <= '0;
            asx_reg       <= '0;
            asy_reg       <= '0;
            mate_reg      <= '0;
            away_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_speed_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready && !emit_go)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        spx_reg   <= self_pos_x;
                        spy_reg   <= self_pos_y;
                        svx_reg   <= self_vel_x;
                        svy_reg   <= self_vel_y;
                        npx_reg   <= nbr_pos_x;
                        npy_reg   <= nbr_pos_y;
                        nvx_reg   <= nbr_vel_x;
                        nvy_reg   <= nbr_vel_y;
                        skip_reg  <= is_self;
                        last_reg  <= last;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if (!skip_reg && (mate_reg < CNT_W'(MAX_NEIGHBORS)))
                    begin
                        vsx_reg   <= sat40(41'(vsx_reg) + 41'(nvx_reg));
                        vsy_reg   <= sat40(41'(vsy_reg) + 41'(nvy_reg));
                        psx_reg   <= sat40(41'(psx_reg) + 41'(npx_reg));
                        psy_reg   <= sat40(41'(psy_reg) + 41'(npy_reg));
                        mate_reg  <= mate_reg + 1'b1;
                        vx_reg    <= sat32(33'(spx_reg) - 33'(npx_reg));
                        vy_reg    <= sat32(33'(spy_reg) - 33'(npy_reg));
                        state_reg <= S_MUL_X;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_MUL_X:
                begin
                    state_reg <= S_MUL_Y;
                end
                S_MUL_Y:
                begin
                    sq_reg    <= prod_reg;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    sq_reg    <= sq_reg + prod_reg;
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if (sq_reg > EPS_SQ)
                    begin
                        if (fin_reg)
                        begin
                            num_reg   <= NW'(sq_reg) << (NW - MUL_W);
                            rem_reg   <= '0;
                            q_reg     <= '0;
                            step_reg  <= STEP_W'(DATA_W);
                            state_reg <= S_SQRT;
                        end
                        else
                        begin
                            op_reg    <= OP_SEP;
                            ax_reg    <= 1'b0;
                            state_reg <= S_DLOAD;
                        end
                    end
                    else if (fin_reg)
                    begin
                        res_reg[{job_reg, 1'b0}] <= '0;
                        res_reg[{job_reg, 1'b1}] <= '0;
                        state_reg                <= S_JOB_NEXT;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_DLOAD:
                begin
                    num_reg   <= ld_num;
                    step_reg  <= ld_n;
                    den_reg   <= ld_den;
                    cap_reg   <= ld_cap;
                    neg_reg   <= ld_neg;
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    ovf_reg   <= 1'b0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= ge ? diff[MUL_W-1:0] : sub_a[MUL_W-1:0];
                    q_reg    <= {q_reg[DATA_W-2:0], ge};
                    ovf_reg  <= ovf_reg | q_reg[DATA_W-1];
                    num_reg  <= num_reg << 1;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == STEP_W'(1))
                    begin
                        state_reg <= S_DDONE;
                    end
                end
                S_DDONE:
                begin
                    case (op_reg)
                        OP_SEP:
                        begin
                            if (!ax_reg)
                            begin
                                asx_reg   <= sat40(41'(asx_reg) + 41'(div_res));
                                ax_reg    <= 1'b1;
                                state_reg <= S_DLOAD;
                            end
                            else
                            begin
                                asy_reg   <= sat40(41'(asy_reg) + 41'(div_res));
                                away_reg  <= away_reg + 1'b1;
                                state_reg <= S_NEXT;
                            end
                        end
                        OP_AVG:
                        begin
                            if (!ax_reg)
                            begin
                                vx_reg    <= avg_res;
                                ax_reg    <= 1'b1;
                                state_reg <= S_DLOAD;
                            end
                            else
                            begin
                                vy_reg    <= (job_reg == 2'd1) ?
                                             sat32(33'(div_res) - 33'(spy_reg)) : div_res;
                                state_reg <= S_MUL_X;
                            end
                        end
                        default:
                        begin
                            res_reg[ridx] <= sat32(33'(div_res) -
                                                   33'(ax_reg ? svy_reg : svx_reg));
                            if (!ax_reg)
                            begin
                                ax_reg    <= 1'b1;
                                state_reg <= S_MULW;
                            end
                            else
                            begin
                                state_reg <= S_JOB_NEXT;
                            end
                        end
                    endcase
                end
                S_SQRT:
                begin
                    rem_reg  <= ge ? diff[MUL_W-1:0] : sub_a[MUL_W-1:0];
                    q_reg    <= {q_reg[DATA_W-2:0], ge};
                    num_reg  <= num_reg << 2;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == STEP_W'(1))
                    begin
                        state_reg <= S_SQDONE;
                    end
                end
                S_SQDONE:
                begin
                    len_reg   <= q_reg;
                    ax_reg    <= 1'b0;
                    state_reg <= S_MULW;
                end
                S_MULW:
                begin
                    op_reg    <= OP_W;
                    state_reg <= S_DLOAD;
                end
                S_NEXT:
                begin
                    if (last_reg)
                    begin
                        fin_reg   <= 1'b1;
                        job_reg   <= 2'd0;
                        state_reg <= S_JOB;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_JOB:
                begin
                    if (job_cnt == '0)
                    begin
                        res_reg[{job_reg, 1'b0}] <= '0;
                        res_reg[{job_reg, 1'b1}] <= '0;
                        state_reg                <= S_JOB_NEXT;
                    end
                    else
                    begin
                        op_reg    <= OP_AVG;
                        ax_reg    <= 1'b0;
                        state_reg <= S_DLOAD;
                    end
                end
                S_JOB_NEXT:
                begin
                    if (job_reg == 2'd2)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        job_reg   <= job_reg + 1'b1;
                        state_reg <= S_JOB;
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_res_reg   <= res_reg;
                        out_total_reg <= TOTAL_W'(mate_reg);
                        out_valid_reg <= 1'b1;
                        vsx_reg       <= '0;
                        vsy_reg       <= '0;
                        psx_reg       <= '0;
                        psy_reg       <= '0;
                        asx_reg       <= '0;
                        asy_reg       <= '0;
                        mate_reg      <= '0;
                        away_reg      <= '0;
                        fin_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign align_x        = out_res_reg[0];
    assign align_y        = out_res_reg[1];
    assign cohere_x       = out_res_reg[2];
    assign cohere_y       = out_res_reg[3];
    assign separate_x     = out_res_reg[4];
    assign separate_y     = out_res_reg[5];
    assign neighbor_total = out_total_reg;

    // Separation terms are a subset of the accepted neighbours.
    a_away_le_mate: assert property (@(posedge clk) disable iff (!rst_n)
        away_reg <= mate_reg)
        else $error("separation count exceeds neighbour count");

    a_mate_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mate_reg <= CNT_W'(MAX_NEIGHBORS))
        else $error("neighbour count beyond its limit");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (den_reg != '0))
        else $error("division started with a zero divisor");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (out_valid && (mate_reg == '0) && (away_reg == '0) && in_ready))
        else $error("result emission did not clear the sums");

endmodule

`default_nettype wire
